// ----- rtl/core/pidc_pkg.sv -----
`default_nettype none

package pidc_pkg;

	localparam int DATA_W       = 32;
	localparam int SAMPLE_W     = 16;
	localparam int ERR_W        = SAMPLE_W + 1;
	localparam int DELTA_W      = SAMPLE_W + 2;
	localparam int RAW_W        = 64;
	localparam int FRAC_W       = 16;
	localparam int REG_IDX_W    = 3;

	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [REG_IDX_W-1:0] REG_KP    = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KI    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KD    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_UPPER = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LOWER = 3'd4;

	localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic signed [ERR_W-1:0]   err;
		logic signed [DATA_W-1:0]  sum;
		logic signed [DELTA_W-1:0] delta;
	} item_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] kp;
		logic signed [DATA_W-1:0] ki;
		logic signed [DATA_W-1:0] kd;
		logic signed [DATA_W-1:0] upper;
		logic signed [DATA_W-1:0] lower;
	} cfg_t;

endpackage

`default_nettype wire

// ----- rtl/core/pid_controller_clamped.sv -----
// PID controller with output clamp. Each accepted item (target_value, measured_value) gives
// exactly one result: drive_value = kp*e + ki_dt*sum(e) + kd_per_dt*(e - e_prev), taken in
// signed Q48.16, checked against the limits (upper first), otherwise rounded half up to an
// integer; was_clamped marks a limited result. The error sum saturates at the signed 32-bit
// range. One item per clock is sustained while out_stall is low. The front updates the
// error state in the acceptance cycle; then a short queue, a product stage with the three
// multipliers, a sum stage and the clamp/output register follow. Registers are written
// through cfg_wr_en/cfg_index/cfg_data, by the user only while no item is in flight; the
// block itself does not enforce this. Indexes beyond the last register are ignored.
`default_nettype none

module pid_controller_clamped #(
	parameter int QUEUE_DEPTH = pidc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [pidc_pkg::REG_IDX_W-1:0]       cfg_index,
	input  wire logic [pidc_pkg::DATA_W-1:0]          cfg_data,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [pidc_pkg::SAMPLE_W-1:0] target_value,
	input  wire logic signed [pidc_pkg::SAMPLE_W-1:0] measured_value,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [pidc_pkg::DATA_W-1:0]        drive_value,
	output logic                                      was_clamped
);
	import pidc_pkg::*;

	cfg_t  cfg_q;
	item_t push_item;
	item_t head;
	logic  push;
	logic  pop;
	logic  not_empty;
	logic  full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp    <= '0;
			cfg_q.ki    <= '0;
			cfg_q.kd    <= '0;
			cfg_q.upper <= INT_MAX;
			cfg_q.lower <= INT_MIN;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_KP:    cfg_q.kp    <= $signed(cfg_data);
				REG_KI:    cfg_q.ki    <= $signed(cfg_data);
				REG_KD:    cfg_q.kd    <= $signed(cfg_data);
				REG_UPPER: cfg_q.upper <= $signed(cfg_data);
				REG_LOWER: cfg_q.lower <= $signed(cfg_data);
				default: begin
				end
			endcase
		end
	end

	assign in_stall = full;

	pidc_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.target_value   (target_value),
		.measured_value (measured_value),
		.queue_full     (full),
		.push           (push),
		.push_item      (push_item)
	);

	pidc_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.not_empty (not_empty),
		.full      (full)
	);

	pidc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.not_empty   (not_empty),
		.cfg         (cfg_q),
		.out_stall   (out_stall),
		.pop         (pop),
		.out_valid   (out_valid),
		.drive_value (drive_value),
		.was_clamped (was_clamped)
	);

endmodule

`default_nettype wire

// ----- rtl/core/pidc_front.sv -----
`default_nettype none

module pidc_front (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   in_valid,
	input  wire logic signed [pidc_pkg::SAMPLE_W-1:0]   target_value,
	input  wire logic signed [pidc_pkg::SAMPLE_W-1:0]   measured_value,
	input  wire logic                                   queue_full,
	output logic                                        push,
	output pidc_pkg::item_t                             push_item
);
	import pidc_pkg::*;

	logic signed [DATA_W-1:0]  error_sum_q;
	logic signed [ERR_W-1:0]   last_error_q;
	logic signed [ERR_W-1:0]   err;
	logic signed [DATA_W:0]    sum_wide;
	logic signed [DATA_W-1:0]  sum_sat;
	logic signed [DELTA_W-1:0] delta;

	assign push = in_valid && !queue_full;

	assign err = $signed({target_value[SAMPLE_W-1], target_value})
		- $signed({measured_value[SAMPLE_W-1], measured_value});

	assign sum_wide = $signed({error_sum_q[DATA_W-1], error_sum_q})
		+ $signed({{(DATA_W+1-ERR_W){err[ERR_W-1]}}, err});

	always_comb begin
		if (sum_wide[DATA_W] != sum_wide[DATA_W-1]) begin
			sum_sat = sum_wide[DATA_W] ? INT_MIN : INT_MAX;
		end else begin
			sum_sat = sum_wide[DATA_W-1:0];
		end
	end

	assign delta = $signed({err[ERR_W-1], err})
		- $signed({last_error_q[ERR_W-1], last_error_q});

	assign push_item.err   = err;
	assign push_item.sum   = sum_sat;
	assign push_item.delta = delta;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q  <= '0;
			last_error_q <= '0;
		end else if (push) begin
			error_sum_q  <= sum_sat;
			last_error_q <= err;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/pidc_queue.sv -----
`default_nettype none

module pidc_queue #(
	parameter int DEPTH = pidc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire pidc_pkg::item_t push_item,
	input  wire logic            pop,
	output pidc_pkg::item_t      head,
	output logic                 not_empty,
	output logic                 full
);
	import pidc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign not_empty = (count_q != '0);
	assign full      = (count_q == CNT_W'(DEPTH));
	assign head      = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		logic [PTR_W-1:0] r;
		if (p == PTR_W'(DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + PTR_W'(1);
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH)) else $error("queue count above depth");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- rtl/core/pidc_back.sv -----
`default_nettype none

module pidc_back (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire pidc_pkg::item_t                      head,
	input  wire logic                                 not_empty,
	input  wire pidc_pkg::cfg_t                       cfg,
	input  wire logic                                 out_stall,
	output logic                                      pop,
	output logic                                      out_valid,
	output logic signed [pidc_pkg::DATA_W-1:0]        drive_value,
	output logic                                      was_clamped
);
	import pidc_pkg::*;

	localparam int PP_W = DATA_W + ERR_W;
	localparam int PI_W = 2 * DATA_W;
	localparam int PD_W = DATA_W + DELTA_W;

	logic                     en;
	logic                     s1_valid_q;
	logic                     s2_valid_q;
	logic                     out_valid_q;
	logic signed [PP_W-1:0]   prod_p_s1;
	logic signed [PI_W-1:0]   prod_i_s1;
	logic signed [PD_W-1:0]   prod_d_s1;
	logic signed [RAW_W-1:0]  raw_s2;
	logic signed [RAW_W-1:0]  hi_lim;
	logic signed [RAW_W-1:0]  lo_lim;
	logic signed [RAW_W-1:0]  rounded;
	logic signed [DATA_W-1:0] drive_q;
	logic                     clamped_q;

	assign en          = !out_valid_q || !out_stall;
	assign pop         = en && not_empty;
	assign out_valid   = out_valid_q;
	assign drive_value = drive_q;
	assign was_clamped = clamped_q;

	assign hi_lim  = $signed({{(RAW_W-DATA_W-FRAC_W){cfg.upper[DATA_W-1]}}, cfg.upper,
		{FRAC_W{1'b0}}});
	assign lo_lim  = $signed({{(RAW_W-DATA_W-FRAC_W){cfg.lower[DATA_W-1]}}, cfg.lower,
		{FRAC_W{1'b0}}});
	assign rounded = raw_s2 + $signed(RAW_W'(1) << (FRAC_W - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			s1_valid_q  <= not_empty;
			s2_valid_q  <= s1_valid_q;
			out_valid_q <= s2_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			prod_p_s1 <= head.err * cfg.kp;
			prod_i_s1 <= head.sum * cfg.ki;
			prod_d_s1 <= head.delta * cfg.kd;
		end
		if (en) begin
			raw_s2 <= RAW_W'(prod_p_s1) + RAW_W'(prod_i_s1) + RAW_W'(prod_d_s1);
		end
		if (en) begin
			if (raw_s2 > hi_lim) begin
				drive_q   <= cfg.upper;
				clamped_q <= 1'b1;
			end else if (raw_s2 < lo_lim) begin
				drive_q   <= cfg.lower;
				clamped_q <= 1'b1;
			end else begin
				drive_q   <= rounded[FRAC_W+DATA_W-1:FRAC_W];
				clamped_q <= 1'b0;
			end
		end
	end

	a_pipe_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(en && s2_valid_q) |=> out_valid_q) else $error("item lost at output stage");

endmodule

`default_nettype wire

// ----- dv/pid_controller_clamped_tb.sv -----
`timescale 1ns / 100ps

module pid_controller_clamped_tb;
	import pidc_pkg::*;

	localparam int CYCLE_LIMIT  = 800_000;
	localparam int RANDOM_ITEMS = 550;
	localparam int PHASES       = 5;
	localparam logic [REG_IDX_W-1:0] REG_SPARE_FIRST = REG_LOWER + 3'd1;

	typedef struct {
		logic signed [DATA_W-1:0] drive;
		logic                     clamped;
	} drive_result_t;

	logic                       clk            = 1'b0;
	logic                       arst_n         = 1'b0;
	logic                       cfg_wr_en      = 1'b0;
	logic [REG_IDX_W-1:0]       cfg_index      = '0;
	logic [DATA_W-1:0]          cfg_data       = '0;
	logic                       in_valid       = 1'b0;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] target_value   = '0;
	logic signed [SAMPLE_W-1:0] measured_value = '0;
	logic                       out_valid;
	logic                       out_stall      = 1'b0;
	logic signed [DATA_W-1:0]   drive_value;
	logic                       was_clamped;

	// controller model state
	logic signed [DATA_W-1:0] kp_m       = '0;
	logic signed [DATA_W-1:0] ki_m       = '0;
	logic signed [DATA_W-1:0] kd_m       = '0;
	logic signed [DATA_W-1:0] upper_m    = INT_MAX;
	logic signed [DATA_W-1:0] lower_m    = INT_MIN;
	logic signed [DATA_W-1:0] err_sum_m  = '0;
	logic signed [ERR_W-1:0]  last_err_m = '0;

	drive_result_t drive_expect_q[$];

	int  fail_count      = 0;
	int  items_sent      = 0;
	int  results_checked = 0;
	int  clamped_seen    = 0;
	int  cycle_count     = 0;
	int  hold_len        = 0;
	bit  src_idle_en     = 1'b1;
	bit  sink_idle_en    = 1'b1;

	pid_controller_clamped dut (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic void predict_drive(logic signed [SAMPLE_W-1:0] t,
			logic signed [SAMPLE_W-1:0] m);
		logic signed [ERR_W-1:0]   err;
		logic signed [DELTA_W-1:0] delta;
		longint                    nsum;
		longint                    raw;
		longint                    hi;
		longint                    lo;
		drive_result_t             res;
		err   = t - m;
		delta = err - last_err_m;
		nsum  = longint'(err_sum_m) + longint'(err);
		if (nsum > longint'(INT_MAX)) begin
			nsum = longint'(INT_MAX);
		end else if (nsum < longint'(INT_MIN)) begin
			nsum = longint'(INT_MIN);
		end
		err_sum_m = nsum[DATA_W-1:0];
		raw = longint'(kp_m) * longint'(err) + longint'(ki_m) * longint'(err_sum_m)
			+ longint'(kd_m) * longint'(delta);
		hi = longint'(upper_m) * 65536;
		lo = longint'(lower_m) * 65536;
		if (raw > hi) begin
			res.drive   = upper_m;
			res.clamped = 1'b1;
		end else if (raw < lo) begin
			res.drive   = lower_m;
			res.clamped = 1'b1;
		end else begin
			raw         = (raw + 32768) >>> FRAC_W;
			res.drive   = raw[DATA_W-1:0];
			res.clamped = 1'b0;
		end
		last_err_m = err;
		drive_expect_q.push_back(res);
		items_sent++;
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_gain();
		case ($urandom_range(0, 7))
			0: begin
				return INT_MAX;
			end
			1: begin
				return INT_MIN;
			end
			2: begin
				return '0;
			end
			default: begin
				return $signed($urandom) >>> $urandom_range(6, 26);
			end
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] rand_limit();
		case ($urandom_range(0, 5))
			0: begin
				return INT_MAX;
			end
			1: begin
				return INT_MIN;
			end
			default: begin
				return $signed($urandom) >>> $urandom_range(0, 24);
			end
		endcase
	endfunction

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] t,
			input logic signed [SAMPLE_W-1:0] m);
		@(negedge clk);
		while (src_idle_en && $urandom_range(0, 99) < 8) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid       <= 1'b1;
		target_value   <= t;
		measured_value <= m;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_drive(t, m);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (drive_expect_q.size() != 0) @(posedge clk);
	endtask

	task automatic set_register(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
		wait_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			REG_KP: begin
				kp_m = val;
			end
			REG_KI: begin
				ki_m = val;
			end
			REG_KD: begin
				kd_m = val;
			end
			REG_UPPER: begin
				upper_m = val;
			end
			REG_LOWER: begin
				lower_m = val;
			end
			default: begin
			end
		endcase
	endtask

	task automatic test_reset_state();
		send_sample(16'sh0000, 16'sh0000);
		send_sample(16'sh7fff, -16'sh8000);
		send_sample(-16'sh8000, 16'sh7fff);
	endtask

	task automatic test_register_map();
		set_register(REG_KP, 32'h0001_0000);
		send_sample(16'sh7fff, -16'sh8000);
		send_sample(-16'sh8000, 16'sh7fff);
		// writes past the last register must leave everything alone
		for (int i = REG_SPARE_FIRST; i < 2 ** REG_IDX_W; i++) begin
			set_register(i[REG_IDX_W-1:0], 32'hffff_ffff);
		end
		send_sample(16'sh0005, 16'sh0001);
		set_register(REG_KP, '0);
		set_register(REG_KD, 32'h0001_0000);
		send_sample(16'sh7fff, -16'sh8000);
		send_sample(-16'sh8000, 16'sh7fff);
		set_register(REG_KD, '0);
		set_register(REG_KI, 32'h0000_0100);
		send_sample(16'sh1234, -16'sh0100);
		send_sample(16'sh0000, 16'sh0000);
		set_register(REG_KI, '0);
	endtask

	task automatic test_rounding();
		set_register(REG_KP, 32'h0000_8000);
		send_sample(16'sh0001, 16'sh0000);
		send_sample(-16'sh0001, 16'sh0000);
		send_sample(16'sh0003, 16'sh0000);
		send_sample(-16'sh0003, 16'sh0000);
	endtask

	task automatic test_clamp_limits();
		set_register(REG_KP, 32'h0001_0000);
		set_register(REG_UPPER, 32'd100);
		set_register(REG_LOWER, -32'sd100);
		send_sample(16'sd100, 16'sd0);
		send_sample(16'sd101, 16'sd0);
		send_sample(-16'sd100, 16'sd0);
		send_sample(-16'sd101, 16'sd0);
		// crossed limits: upper test wins
		set_register(REG_UPPER, -32'sd5);
		set_register(REG_LOWER, 32'sd5);
		send_sample(16'sd0, 16'sd0);
		send_sample(-16'sd10, 16'sd0);
		set_register(REG_UPPER, INT_MIN);
		set_register(REG_LOWER, INT_MAX);
		send_sample(16'sd0, 16'sd0);
		set_register(REG_UPPER, INT_MAX);
		set_register(REG_LOWER, INT_MIN);
		set_register(REG_KP, INT_MAX);
		set_register(REG_KD, INT_MIN);
		send_sample(16'sh7fff, -16'sh8000);
		send_sample(-16'sh8000, 16'sh7fff);
		set_register(REG_KP, INT_MIN);
		set_register(REG_KD, INT_MAX);
		send_sample(16'sh7fff, -16'sh8000);
		send_sample(-16'sh8000, 16'sh7fff);
	endtask

	task automatic test_random_phases();
		logic signed [SAMPLE_W-1:0] t;
		logic signed [SAMPLE_W-1:0] m;
		int                         base;
		int                         near;
		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase == 0) begin
				set_register(REG_KP, INT_MAX);
				set_register(REG_KI, INT_MIN);
				set_register(REG_KD, INT_MAX);
				set_register(REG_UPPER, INT_MAX);
				set_register(REG_LOWER, INT_MIN);
			end else begin
				set_register(REG_KP, rand_gain());
				set_register(REG_KI, rand_gain());
				set_register(REG_KD, rand_gain());
				set_register(REG_UPPER, rand_limit());
				set_register(REG_LOWER, rand_limit());
			end
			src_idle_en  = (phase != 1);
			sink_idle_en = (phase != 1);
			for (int i = 0; i < RANDOM_ITEMS / PHASES; i++) begin
				if (phase == 2 && i == 20) begin
					hold_len = 80;
				end
				if (phase == 3 && i == 50) begin
					wait_idle();
				end
				case ($urandom_range(0, 9))
					0: begin
						t = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
						m = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
					end
					1, 2, 3: begin
						// hovering near the setpoint
						base = int'($urandom_range(0, 65535)) - 32768;
						near = base + int'($urandom_range(0, 64)) - 32;
						if (near > 32767) begin
							near = 32767;
						end else if (near < -32768) begin
							near = -32768;
						end
						t = SAMPLE_W'(base);
						m = SAMPLE_W'(near);
					end
					default: begin
						t = SAMPLE_W'($urandom);
						m = SAMPLE_W'($urandom);
					end
				endcase
				send_sample(t, m);
			end
		end
		src_idle_en  = 1'b1;
		sink_idle_en = 1'b1;
	endtask

	always @(negedge clk) begin
		if (hold_len > 0) begin
			out_stall <= 1'b1;
			hold_len  <= hold_len - 1;
		end else begin
			out_stall <= sink_idle_en && ($urandom_range(0, 99) < 8);
		end
	end

	always @(posedge clk) begin : check_drive
		drive_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (drive_expect_q.size() == 0) begin
				$error("result with no item pending: drive_value %0d was_clamped %0b",
					drive_value, was_clamped);
				fail_count++;
			end else begin
				want = drive_expect_q.pop_front();
				results_checked++;
				if (want.clamped) begin
					clamped_seen++;
				end
				if (drive_value !== want.drive) begin
					$error("drive_value: expected %0d, got %0d", want.drive, drive_value);
					fail_count++;
				end
				if (was_clamped !== want.clamped) begin
					$error("was_clamped: expected %0b, got %0b", want.clamped, was_clamped);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, drive_expect_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_state();
		test_register_map();
		test_rounding();
		test_clamp_limits();
		test_random_phases();
		wait_idle();
		repeat (8) @(posedge clk);
		if (drive_expect_q.size() != 0) begin
			$error("%0d expected results never arrived", drive_expect_q.size());
			fail_count++;
		end
		$display("%0d items sent, %0d results checked (%0d clamped)",
			items_sent, results_checked, clamped_seen);
		$display("gain and limit extremes, crossed limits, rounding, long output backpressure");
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
